// ----- hdl/gse_pkg.sv -----
// Shared types and defaults for the gap exchange sorter.
// Used by the sorting cell, the top level and the testbench top; depends on nothing else.
package gse_pkg;

    // Default sizes, handed to the top level's parameters.
    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // What every cell of the chain does.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHL,
        CELL_SHR
    } t_cell_op;

    // Control word broadcast from the sequencer to the chain.
    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

// ----- hdl/gse_cell.sv -----
// One cell of the sorting chain: holds one value and passes values to its neighbors.
// Depends on gse_pkg for the control word.
module gse_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gse_pkg::t_cell_ctl     i_ctl,
    // Value rippling in from the left neighbor (or from the input port).
    input  logic [DATA_WIDTH-1:0]  i_in_val,
    input  logic                   i_in_vld,
    // Held values of both neighbors, used while draining.
    input  logic [DATA_WIDTH-1:0]  i_left_val,
    input  logic                   i_left_vld,
    input  logic [DATA_WIDTH-1:0]  i_right_val,
    input  logic                   i_right_vld,
    output logic [DATA_WIDTH-1:0]  o_held_val,
    output logic                   o_held_vld,
    output logic [DATA_WIDTH-1:0]  o_pass_val,
    output logic                   o_pass_vld
);
    import gse_pkg::*;

    logic [DATA_WIDTH-1:0] r_val;
    logic                  r_vld;
    logic [DATA_WIDTH-1:0] r_pass_val;
    logic                  r_pass_vld;
    logic                  w_in_less;

    // The incoming value goes before the held one when it is strictly smaller.
    assign w_in_less = $signed(i_in_val) < $signed(r_val);

    // Insert: keep the smaller value, hand the larger one to the right next cycle. Shift: take a neighbor's held value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                CELL_INSERT: begin
                    r_pass_vld <= i_in_vld && r_vld;
                    if (i_in_vld) begin
                        if (!r_vld) begin
                            r_val <= i_in_val;
                            r_vld <= 1'b1;
                        end else if (w_in_less) begin
                            r_val      <= i_in_val;
                            r_pass_val <= r_val;
                        end else begin
                            r_pass_val <= i_in_val;
                        end
                    end
                end
                CELL_SHL: begin
                    r_val      <= i_right_val;
                    r_vld      <= i_right_vld;
                    r_pass_vld <= 1'b0;
                end
                CELL_SHR: begin
                    r_val      <= i_left_val;
                    r_vld      <= i_left_vld;
                    r_pass_vld <= 1'b0;
                end
                CELL_HOLD: begin
                    r_pass_vld <= 1'b0;
                end
                default: begin
                    r_pass_vld <= 1'b0;
                end
            endcase
        end
    end

    assign o_held_val = r_val;
    assign o_held_vld = r_vld;
    assign o_pass_val = r_pass_val;
    assign o_pass_vld = r_pass_vld;

endmodule

// ----- hdl/gap_exchange_sorter.sv -----
// Top level of the gap exchange sorter: sequencer, chain of sorting cells, output register.
// Depends on gse_pkg and gse_cell.
//
// The block collects a set of signed values, one transfer per cycle while loading, into a
// chain of DEPTH cells that keeps them in ascending order as they arrive; each value ripples
// one cell per cycle. The transfer that carries last_in closes the set and samples the
// descending bit. The chain then settles and no input is taken. The sorted values come out
// one per cycle while the consumer takes them; in descending order the chain drains from
// its far end, where the empty cells are. Values that arrive with DEPTH values already
// held are dropped, and overflow is then set on every result of that set.
module gap_exchange_sorter #(
    parameter int DEPTH      = gse_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = gse_pkg::DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic                   i_last_in,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DATA_WIDTH-1:0]  o_sorted_value,
    output logic                   o_last_out,
    output logic                   o_overflow
);
    import gse_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN
    } t_state;

    t_state                r_state;
    logic                  r_desc;
    logic                  r_dir;
    logic                  r_ovf;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_timer;
    logic [CW-1:0]         r_left;
    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_val;
    logic                  r_out_last;

    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic                  w_store;
    logic                  w_load_out;
    logic [DATA_WIDTH-1:0] w_src_val;
    logic                  w_src_vld;
    t_cell_ctl             w_ctl;

    logic [DATA_WIDTH-1:0] w_held_val [DEPTH];
    logic                  w_held_vld [DEPTH];
    logic [DATA_WIDTH-1:0] w_pass_val [DEPTH];
    logic                  w_pass_vld [DEPTH];

    // Handshake decode.
    assign o_ready    = (r_state == ST_LOAD);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = r_out_vld && i_ready;
    assign w_store    = w_in_xfer && (r_count < DEPTH_C);

    // The output register takes the next drained value when it is empty or being taken.
    assign w_load_out = (r_state == ST_DRAIN) && (r_left != '0) && (!r_out_vld || i_ready);
    assign w_src_val  = r_dir ? w_held_val[DEPTH-1] : w_held_val[0];
    assign w_src_vld  = r_dir ? w_held_vld[DEPTH-1] : w_held_vld[0];

    // Chain control: insert while loading and settling, shift one way while draining.
    always_comb begin
        w_ctl.op = CELL_HOLD;
        unique case (r_state)
            ST_LOAD, ST_SETTLE: begin
                w_ctl.op = CELL_INSERT;
            end
            ST_DRAIN: begin
                if (w_load_out) begin
                    w_ctl.op = r_dir ? CELL_SHR : CELL_SHL;
                end
            end
            default: begin
                w_ctl.op = CELL_HOLD;
            end
        endcase
    end

    // The chain of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_in_val;
        logic                  w_in_vld;
        logic [DATA_WIDTH-1:0] w_lval;
        logic                  w_lvld;
        logic [DATA_WIDTH-1:0] w_rval;
        logic                  w_rvld;

        if (g == 0) begin : g_first
            assign w_in_val = i_value;
            assign w_in_vld = w_store;
            assign w_lval   = '0;
            assign w_lvld   = 1'b0;
        end else begin : g_inner
            assign w_in_val = w_pass_val[g-1];
            assign w_in_vld = w_pass_vld[g-1];
            assign w_lval   = w_held_val[g-1];
            assign w_lvld   = w_held_vld[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_rval = '0;
            assign w_rvld = 1'b0;
        end else begin : g_mid
            assign w_rval = w_held_val[g+1];
            assign w_rvld = w_held_vld[g+1];
        end

        gse_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_in_val    (w_in_val),
            .i_in_vld    (w_in_vld),
            .i_left_val  (w_lval),
            .i_left_vld  (w_lvld),
            .i_right_val (w_rval),
            .i_right_vld (w_rvld),
            .o_held_val  (w_held_val[g]),
            .o_held_vld  (w_held_vld[g]),
            .o_pass_val  (w_pass_val[g]),
            .o_pass_vld  (w_pass_vld[g])
        );
    end

    // Sequencer, configuration register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_desc     <= 1'b0;
            r_dir      <= 1'b0;
            r_ovf      <= 1'b0;
            r_count    <= '0;
            r_timer    <= '0;
            r_left     <= '0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_desc <= i_cfg_data;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_xfer) begin
                        if (w_store) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_in) begin
                            r_dir   <= r_desc;
                            r_timer <= DEPTH_C;
                            r_left  <= w_store ? r_count + CW'(1) : r_count;
                            r_state <= ST_SETTLE;
                        end
                    end
                end
                ST_SETTLE: begin
                    r_timer <= r_timer - CW'(1);
                    if (r_timer == CW'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_load_out) begin
                        r_out_vld <= w_src_vld;
                        r_out_val <= w_src_val;
                        if (w_src_vld) begin
                            r_left     <= r_left - CW'(1);
                            r_out_last <= (r_left == CW'(1));
                        end
                    end else if (w_out_xfer) begin
                        r_out_vld <= 1'b0;
                    end
                    // Set is done once the final result has been taken.
                    if ((r_left == '0) && (!r_out_vld || i_ready)) begin
                        r_out_vld <= 1'b0;
                        r_count   <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_valid        = r_out_vld;
    assign o_sorted_value = r_out_val;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_ovf;

    // Input and output sides are never open in the same cycle.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output handshakes open together");

    // Nothing follows the final result of a set.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_out) |=> !o_valid)
        else $error("result issued after the final one");

    // The fill count never passes the chain length.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count beyond chain length");

    // A result only comes out during the drain phase.
    a_drain_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_DRAIN))
        else $error("result outside the drain phase");

endmodule

// ----- test/gap_exchange_sorter_check.sv -----
`timescale 1ns / 1ps
// Scoreboard for the gap exchange sorter: watches the register, load and result ports,
// predicts every sorted set and compares each result transfer field by field.
// Depends only on the signals it is connected to; it drives nothing into the block.
module gap_exchange_sorter_check #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [DATA_WIDTH-1:0] i_in_value,
    input  logic                  i_in_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [DATA_WIDTH-1:0] i_out_value,
    input  logic                  i_out_last,
    input  logic                  i_out_overflow,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
        logic                         overflow;
    } t_sorted_entry;

    // Set being collected, the direction register and the results still owed.
    logic signed [DATA_WIDTH-1:0] set_values [DEPTH];
    int                           set_count;
    logic                         set_overflow;
    logic                         descending;
    t_sorted_entry                sorted_queue [$];
    int                           fail_count = 0;
    int                           pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Compare one field of a result and report it if it differs.
    task automatic check_field(input string name, input longint expected, input longint actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, expected, actual);
            fail_count++;
        end
    endtask

    // Order the collected set in the selected direction and queue one result per value.
    // Equal values are indistinguishable, so any correct sort gives the same results.
    task automatic predict_sorted_set();
        logic signed [DATA_WIDTH-1:0] ordered [DEPTH];
        logic signed [DATA_WIDTH-1:0] key;
        int                           j;
        t_sorted_entry                entry;
        for (int i = 0; i < set_count; i++) begin
            key = set_values[i];
            j   = i;
            while (j > 0 && (descending ? ordered[j-1] < key : ordered[j-1] > key)) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        for (int i = 0; i < set_count; i++) begin
            entry.value    = ordered[i];
            entry.last     = (i == set_count - 1);
            entry.overflow = set_overflow;
            sorted_queue.push_back(entry);
        end
    endtask

    // Follow every transfer on the rising edge.
    always @(posedge i_clk) begin : watch
        t_sorted_entry head;
        if (!i_rst_n) begin
            set_count     = 0;
            set_overflow  = 1'b0;
            descending    = 1'b0;
            sorted_queue.delete();
            pending_count = 0;
        end else begin
            if (i_cfg_we)
                descending = i_cfg_data;

            // A load transfer: store it, or drop it when the store is full.
            if (i_in_valid && i_in_ready) begin
                if (set_count < DEPTH) begin
                    set_values[set_count] = i_in_value;
                    set_count++;
                end else begin
                    set_overflow = 1'b1;
                end
                if (i_in_last) begin
                    predict_sorted_set();
                    set_count    = 0;
                    set_overflow = 1'b0;
                end
            end

            // A result transfer: it must match the oldest expected result.
            if (i_out_valid && i_out_ready) begin
                if (sorted_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0d",
                             $time, $signed(i_out_value));
                    fail_count++;
                end else begin
                    head = sorted_queue.pop_front();
                    check_field("sorted_value", head.value, $signed(i_out_value));
                    check_field("last_out", head.last, i_out_last);
                    check_field("overflow", head.overflow, i_out_overflow);
                end
            end
            pending_count = sorted_queue.size();
        end
    end

endmodule

// ----- test/gap_exchange_sorter_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the gap exchange sorter: clock, reset, stimulus and the verdict.
// Depends on gse_pkg, gap_exchange_sorter and gap_exchange_sorter_check.
module gap_exchange_sorter_test;

    localparam int DEPTH         = gse_pkg::DEPTH_DEF;
    localparam int DATA_WIDTH    = gse_pkg::DATA_WIDTH_DEF;
    localparam int ITEM_TARGET   = 480;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic signed [DATA_WIDTH-1:0] MOST_NEGATIVE = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] MOST_POSITIVE = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // How the values of one set are drawn.
    typedef enum int {
        FILL_ANY,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_MIXED
    } t_fill_kind;

    // How the result side holds off transfers during one stretch.
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [DATA_WIDTH-1:0] i_value;
    logic                  i_last_in;
    logic                  o_valid;
    logic                  i_ready;
    logic [DATA_WIDTH-1:0] o_sorted_value;
    logic                  o_last_out;
    logic                  o_overflow;

    int checker_fail_count;
    int pending_results;
    int sent_count = 0;
    int burst_left = 1;
    int cycle_count;

    logic signed [DATA_WIDTH-1:0] set_buffer [$];

    always #10 i_clk = ~i_clk;

    gap_exchange_sorter #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    gap_exchange_sorter_check #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_in_value     (i_value),
        .i_in_last      (i_last_in),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_out_value    (o_sorted_value),
        .i_out_last     (o_last_out),
        .i_out_overflow (o_overflow),
        .o_fail_count   (checker_fail_count),
        .o_pending      (pending_results)
    );

    // Draw one value of the given kind.
    function automatic logic signed [DATA_WIDTH-1:0] make_value(input t_fill_kind kind);
        t_fill_kind pick;
        int         offset;
        pick = kind;
        if (kind == FILL_MIXED)
            pick = t_fill_kind'($urandom_range(0, 2));
        case (pick)
            FILL_NARROW: begin
                offset = $urandom_range(0, 8);
                return DATA_WIDTH'(offset - 4);
            end
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return MOST_NEGATIVE;
                    1:       return MOST_POSITIVE;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return DATA_WIDTH'({$urandom, $urandom});
        endcase
    endfunction

    // Mostly small sets, some large ones, a few exactly full and a few that overflow.
    function automatic int pick_set_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $urandom_range(1, 8);
        else if (roll < 85)
            return $urandom_range(9, DEPTH - 1);
        else if (roll < 92)
            return DEPTH;
        else
            return $urandom_range(DEPTH + 1, DEPTH + 6);
    endfunction

    // One load transfer; the sender pauses at random between bursts.
    task automatic send_value(input logic signed [DATA_WIDTH-1:0] value, input logic last);
        int gap_cycles;
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_value   <= value;
        i_last_in <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sent_count++;
        burst_left--;
        if (burst_left <= 0) begin
            gap_cycles = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap_cycles - 1)
                @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 12);
        end
    endtask

    // Send the buffered values as one set, last_in on the final one.
    task automatic send_buffered_set();
        foreach (set_buffer[i])
            send_value(set_buffer[i], i == set_buffer.size() - 1);
        set_buffer.delete();
    endtask

    task automatic send_random_set(input int size, input t_fill_kind kind);
        for (int i = 0; i < size; i++)
            send_value(make_value(kind), i == size - 1);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES)
            @(negedge i_clk);
    endtask

    task automatic write_direction(input logic descending);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= descending;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Result side: stretches of steady acceptance, random stalls and a fixed pattern.
    initial begin : result_stall
        t_stall_mode mode;
        int          stretch;
        i_ready = 1'b0;
        forever begin
            mode    = t_stall_mode'($urandom_range(0, 2));
            stretch = $urandom_range(8, 80);
            for (int i = 0; i < stretch; i++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:   i_ready <= 1'b1;
                    STALL_RANDOM: i_ready <= ($urandom_range(0, 9) < 6);
                    default:      i_ready <= ((i % 5) < 3);
                endcase
            end
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("gap_exchange_sorter_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 1'b0;
        i_valid    = 1'b0;
        i_value    = '0;
        i_last_in  = 1'b0;
        repeat (11)
            @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Ascending: single value, the two extremes, equal values, mixed signs.
        write_direction(1'b0);
        set_buffer = '{MOST_POSITIVE};
        send_buffered_set();
        set_buffer = '{MOST_POSITIVE, MOST_NEGATIVE};
        send_buffered_set();
        set_buffer = '{5, -1, 5};
        send_buffered_set();
        set_buffer = '{0, -1, MOST_NEGATIVE, MOST_POSITIVE, 1};
        send_buffered_set();

        // Descending: the two extremes, equal values, a single value and an ascending run.
        wait_idle();
        write_direction(1'b1);
        set_buffer = '{MOST_NEGATIVE, MOST_POSITIVE};
        send_buffered_set();
        set_buffer = '{-3, -3, 2};
        send_buffered_set();
        set_buffer = '{1};
        send_buffered_set();
        set_buffer = '{1, 2, 3, 4, 5, 6};
        send_buffered_set();

        // Random phases, each with a fresh direction.
        while (sent_count < ITEM_TARGET) begin
            wait_idle();
            write_direction(1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 5))
                send_random_set(pick_set_size(), t_fill_kind'($urandom_range(0, 3)));
        end

        wait_idle();
        if (checker_fail_count == 0 && pending_results == 0)
            $display("gap_exchange_sorter_test OK");
        else
            $display("gap_exchange_sorter_test NOT OK");
        $finish;
    end

endmodule
